// ----- rtl/assembly_token_lexer_assert.svh -----
// Assertion macros for the assembly token lexer.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef ASSEMBLY_TOKEN_LEXER_ASSERT_SVH
`define ASSEMBLY_TOKEN_LEXER_ASSERT_SVH

`ifndef ASSERT_OFF
`define ATL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ATL_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ATL_ASSERT(lbl, prop, msg)
`define ATL_NEVER(lbl, cond, msg)
`endif

`endif

// ----- rtl/atl_pkg.sv -----
// Shared types for the assembly token lexer: byte classes, token kinds,
// result records and the result bundle. No dependencies.
package atl_pkg;

  localparam int OUT_IDX_W  = 32;
  localparam int OUT_LINE_W = 24;
  localparam int OUT_COL_W  = 16;
  localparam int MAX_RES    = 3;

  typedef enum logic [3:0] {
    C_LETTER, C_DIGIT, C_HASH, C_MINUS, C_DOLLAR, C_SEMI,
    C_COLON, C_LF, C_CR, C_BLANK, C_NUL, C_OTHER
  } cls_t;

  typedef enum logic [3:0] {
    K_DIR, K_NUM, K_REG, K_LABEL, K_IDENT, K_COMMENT, K_NEWLINE, K_ERROR, K_END
  } kind_t;

  typedef struct packed {
    cls_t cls;
    logic fin;
  } entry_t;

  typedef struct packed {
    kind_t                 kind;
    logic [OUT_IDX_W-1:0]  start;
    logic [OUT_IDX_W-1:0]  len;
    logic [OUT_LINE_W-1:0] line;
    logic [OUT_COL_W-1:0]  col;
  } tok_t;

  typedef struct packed {
    tok_t [MAX_RES-1:0] tok;
    logic [1:0]         cnt;
  } bundle_t;

endpackage

// ----- rtl/atl_front.sv -----
// Front end: classifies incoming source bytes and queues them for the scanner.
// Depends on atl_pkg.
module atl_front import atl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_source_byte,
  input  logic       in_final_byte,
  output logic       q_valid,
  output entry_t     q_entry,
  input  logic       q_deq
);

  localparam int QD = 2;
  localparam int PW = $clog2(QD);

  entry_t          mem_r [QD];
  logic [PW-1:0]   wp_r, rp_r;
  logic [PW:0]     cnt_r;
  logic            wr;
  entry_t          new_entry;

  function automatic cls_t classify(input logic [7:0] c);
    cls_t r;
    if (c >= 8'h41 && c <= 8'h7A)      r = C_LETTER;
    else if (c >= 8'h30 && c <= 8'h39) r = C_DIGIT;
    else if (c == 8'h23)               r = C_HASH;
    else if (c == 8'h2D)               r = C_MINUS;
    else if (c == 8'h24)               r = C_DOLLAR;
    else if (c == 8'h3B)               r = C_SEMI;
    else if (c == 8'h3A)               r = C_COLON;
    else if (c == 8'h0A)               r = C_LF;
    else if (c == 8'h0D)               r = C_CR;
    else if (c == 8'h20 || c == 8'h09) r = C_BLANK;
    else if (c == 8'h00)               r = C_NUL;
    else                               r = C_OTHER;
    return r;
  endfunction

  assign full      = (cnt_r == (PW+1)'(QD));
  assign q_valid   = (cnt_r != '0);
  assign q_entry   = mem_r[rp_r];
  assign wr        = push && !full;
  assign new_entry = '{cls: classify(in_source_byte), fin: in_final_byte};

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= PW'(wp_r + 1'b1);
      if (q_deq) rp_r <= PW'(rp_r + 1'b1);
      cnt_r <= (PW+1)'(cnt_r + (PW+1)'(wr) - (PW+1)'(q_deq));
    end
  end

endmodule

// ----- rtl/atl_engine.sv -----
// Scanner engine: runs the token state machine on one classified byte per cycle
// while its results are taken by the output stage. Depends on atl_pkg.
module atl_engine import atl_pkg::*; #(
  parameter int INDEX_BITS  = 32,
  parameter int LINE_BITS   = 24,
  parameter int COLUMN_BITS = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  input  entry_t  q_entry,
  output logic    q_deq,
  output logic    bun_valid,
  output bundle_t bun,
  input  logic    bun_ready
);

  typedef enum logic [3:0] {
    M_IDLE, M_DIR0, M_DIR, M_MINUS, M_NUM, M_DOLLAR, M_REG, M_WORD, M_COMMENT, M_CR
  } mode_t;

  typedef logic [INDEX_BITS-1:0]  idx_t;
  typedef logic [LINE_BITS-1:0]   ln_t;
  typedef logic [COLUMN_BITS-1:0] col_t;

  mode_t mode_r, m;
  logic  stop_r, stop;
  idx_t  pos_r, pos, ps_r, ps, pl_r, pl;
  ln_t   line_r, ln, pln_r, pln;
  col_t  col_r, cl, pc_r, pc;
  logic  [1:0] n;
  tok_t  [MAX_RES-1:0] toks;
  logic  restart;
  cls_t  c;

  function automatic idx_t sat_idx(input idx_t v);
    return (&v) ? v : INDEX_BITS'(v + 1'b1);
  endfunction

  function automatic ln_t sat_ln(input ln_t v);
    return (&v) ? v : LINE_BITS'(v + 1'b1);
  endfunction

  function automatic col_t sat_col(input col_t v);
    return (&v) ? v : COLUMN_BITS'(v + 1'b1);
  endfunction

  function automatic tok_t mk_tok(input kind_t k, input idx_t s, input idx_t l,
                                  input ln_t lr, input col_t cr);
    tok_t t;
    t.kind  = k;
    t.start = OUT_IDX_W'(s);
    t.len   = OUT_IDX_W'(l);
    t.line  = OUT_LINE_W'(lr);
    t.col   = OUT_COL_W'(cr);
    return t;
  endfunction

  assign c = q_entry.cls;

  always_comb begin
    m       = mode_r;
    stop    = stop_r;
    pos     = pos_r;
    ln      = line_r;
    cl      = col_r;
    ps      = ps_r;
    pl      = pl_r;
    pln     = pln_r;
    pc      = pc_r;
    n       = '0;
    toks    = '0;
    restart = 1'b0;
    if (!stop_r) begin
      unique case (mode_r)
        M_DIR0, M_MINUS, M_DOLLAR: begin
          if ((mode_r == M_DIR0 && c == C_LETTER) || (mode_r != M_DIR0 && c == C_DIGIT)) begin
            m   = (mode_r == M_DIR0) ? M_DIR : (mode_r == M_MINUS) ? M_NUM : M_REG;
            pos = INDEX_BITS'(pos + 1'b1);
            cl  = sat_col(cl);
            pl  = sat_idx(pl);
          end else begin
            toks[n] = mk_tok(K_ERROR, ps, '0, pln, pc);
            n       = 2'(n + 1'b1);
            m       = M_IDLE;
            stop    = 1'b1;
          end
        end
        M_CR: begin
          if (c == C_LF) begin
            pos     = INDEX_BITS'(pos + 1'b1);
            cl      = sat_col(cl);
            pl      = sat_idx(pl);
            toks[n] = mk_tok(K_NEWLINE, ps, pl, pln, pc);
            n       = 2'(n + 1'b1);
            m       = M_IDLE;
            ln      = sat_ln(ln);
            cl      = '0;
          end else begin
            toks[n] = mk_tok(K_ERROR, ps, '0, pln, pc);
            n       = 2'(n + 1'b1);
            m       = M_IDLE;
            stop    = 1'b1;
          end
        end
        M_DIR, M_NUM, M_REG, M_COMMENT: begin
          if ((mode_r == M_DIR && c == C_LETTER) ||
              ((mode_r == M_NUM || mode_r == M_REG) && c == C_DIGIT) ||
              (mode_r == M_COMMENT && c != C_CR && c != C_LF && c != C_NUL)) begin
            pos = INDEX_BITS'(pos + 1'b1);
            cl  = sat_col(cl);
            pl  = sat_idx(pl);
          end else begin
            toks[n] = mk_tok((mode_r == M_DIR) ? K_DIR :
                             (mode_r == M_NUM) ? K_NUM :
                             (mode_r == M_REG) ? K_REG : K_COMMENT, ps, pl, pln, pc);
            n       = 2'(n + 1'b1);
            m       = M_IDLE;
            restart = 1'b1;
          end
        end
        M_WORD: begin
          if (c == C_LETTER || c == C_DIGIT) begin
            pos = INDEX_BITS'(pos + 1'b1);
            cl  = sat_col(cl);
            pl  = sat_idx(pl);
          end else if (c == C_COLON) begin
            pos     = INDEX_BITS'(pos + 1'b1);
            cl      = sat_col(cl);
            pl      = sat_idx(pl);
            toks[n] = mk_tok(K_LABEL, ps, pl, pln, pc);
            n       = 2'(n + 1'b1);
            m       = M_IDLE;
          end else begin
            toks[n] = mk_tok(K_IDENT, ps, pl, pln, pc);
            n       = 2'(n + 1'b1);
            m       = M_IDLE;
            restart = 1'b1;
          end
        end
        default: begin
          m       = M_IDLE;
          restart = 1'b1;
        end
      endcase

      // start a new token from this byte, skip a blank or flag a bad byte
      if (restart) begin
        unique case (c)
          C_HASH, C_MINUS, C_DIGIT, C_DOLLAR, C_LETTER, C_SEMI, C_LF, C_CR: begin
            unique case (c)
              C_HASH:   m = M_DIR0;
              C_MINUS:  m = M_MINUS;
              C_DIGIT:  m = M_NUM;
              C_DOLLAR: m = M_DOLLAR;
              C_LETTER: m = M_WORD;
              C_SEMI:   m = M_COMMENT;
              default:  m = M_CR;
            endcase
            ps  = pos;
            pln = ln;
            pc  = cl;
            pl  = idx_t'(1);
            pos = INDEX_BITS'(pos + 1'b1);
            cl  = sat_col(cl);
            if (c == C_LF) begin
              toks[n] = mk_tok(K_NEWLINE, ps, pl, pln, pc);
              n       = 2'(n + 1'b1);
              m       = M_IDLE;
              ln      = sat_ln(ln);
              cl      = '0;
            end
          end
          C_BLANK: begin
            pos = INDEX_BITS'(pos + 1'b1);
            cl  = sat_col(cl);
          end
          default: begin
            toks[n] = mk_tok(K_ERROR, pos, '0, ln, cl);
            n       = 2'(n + 1'b1);
            stop    = 1'b1;
          end
        endcase
      end

      // flush the pending token and close the stream on the last byte
      if (q_entry.fin && !stop) begin
        unique case (m)
          M_IDLE: begin
          end
          M_DIR, M_NUM, M_REG, M_WORD, M_COMMENT: begin
            toks[n] = mk_tok((m == M_DIR) ? K_DIR :
                             (m == M_NUM) ? K_NUM :
                             (m == M_REG) ? K_REG :
                             (m == M_WORD) ? K_IDENT : K_COMMENT, ps, pl, pln, pc);
            n       = 2'(n + 1'b1);
          end
          default: begin
            toks[n] = mk_tok(K_ERROR, ps, '0, pln, pc);
            n       = 2'(n + 1'b1);
            stop    = 1'b1;
          end
        endcase
        if (!stop) begin
          toks[n] = mk_tok(K_END, pos, '0, ln, cl);
          n       = 2'(n + 1'b1);
          stop    = 1'b1;
        end
        m = M_IDLE;
      end
    end
  end

  assign q_deq     = q_valid && ((n == '0) || bun_ready);
  assign bun_valid = q_valid && (n != '0);
  assign bun.tok   = toks;
  assign bun.cnt   = n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      stop_r <= 1'b0;
      pos_r  <= '0;
      line_r <= '0;
      col_r  <= '0;
      ps_r   <= '0;
      pl_r   <= '0;
      pln_r  <= '0;
      pc_r   <= '0;
    end else if (q_deq) begin
      mode_r <= m;
      stop_r <= stop;
      pos_r  <= pos;
      line_r <= ln;
      col_r  <= cl;
      ps_r   <= ps;
      pl_r   <= pl;
      pln_r  <= pln;
      pc_r   <= pc;
    end
  end

endmodule

// ----- rtl/atl_serial.sv -----
// Output stage: holds one bundle of results and presents them one beat at a
// time on the result queue ports. Depends on atl_pkg.
module atl_serial import atl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  bun_valid,
  input  bundle_t               bun,
  output logic                  bun_ready,
  output logic                  empty,
  input  logic                  pop,
  output logic [3:0]            out_token_kind,
  output logic [OUT_IDX_W-1:0]  out_start_index,
  output logic [OUT_IDX_W-1:0]  out_token_length,
  output logic [OUT_LINE_W-1:0] out_line_number,
  output logic [OUT_COL_W-1:0]  out_column_number,
  output logic                  out_last_of_run
);

  tok_t [MAX_RES-1:0] tok_r;
  logic [1:0]         cnt_r, ptr_r;
  logic               last;
  tok_t               cur;

  assign empty             = (cnt_r == '0);
  assign last              = (ptr_r == 2'(cnt_r - 1'b1));
  assign bun_ready         = empty || (pop && last);
  assign cur               = tok_r[ptr_r];
  assign out_token_kind    = cur.kind;
  assign out_start_index   = cur.start;
  assign out_token_length  = cur.len;
  assign out_line_number   = cur.line;
  assign out_column_number = cur.col;
  assign out_last_of_run   = last;

  always_ff @(posedge clk) begin
    if (bun_valid && bun_ready) begin
      tok_r <= bun.tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ptr_r <= '0;
    end else if (bun_valid && bun_ready) begin
      cnt_r <= bun.cnt;
      ptr_r <= '0;
    end else if (pop && !empty) begin
      if (last) begin
        cnt_r <= '0;
        ptr_r <= '0;
      end else begin
        ptr_r <= 2'(ptr_r + 1'b1);
      end
    end
  end

endmodule

// ----- rtl/assembly_token_lexer.sv -----
// Top level of the assembly token lexer: front queue, scanner engine, output stage.
// Depends on atl_pkg, atl_front, atl_engine, atl_serial and the assert macros.
//
//   channel  | handshake         | payload
//   ---------+-------------------+---------------------------------------------
//   input    | push / full       | in_source_byte, in_final_byte
//   result   | empty / pop       | out_token_kind, out_start_index, out_token_length,
//            |                   | out_line_number, out_column_number, out_last_of_run
//
// The scanner takes one byte per cycle from a two-entry front queue, while the
// output stage takes its results. A byte that causes k results holds the output
// stage for k beats; bytes that cause none pass without waiting on it. A byte is
// registered in the front queue, and its results in the output stage.
// Reset (rst_n low at a clock edge) returns to line 0, column 0, offset 0.
// A stalled result side fills the front queue and then raises full.
`include "assembly_token_lexer_assert.svh"

module assembly_token_lexer import atl_pkg::*; #(
  parameter int INDEX_BITS  = 32,
  parameter int LINE_BITS   = 24,
  parameter int COLUMN_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            in_source_byte,
  input  logic                  in_final_byte,
  output logic                  empty,
  input  logic                  pop,
  output logic [3:0]            out_token_kind,
  output logic [OUT_IDX_W-1:0]  out_start_index,
  output logic [OUT_IDX_W-1:0]  out_token_length,
  output logic [OUT_LINE_W-1:0] out_line_number,
  output logic [OUT_COL_W-1:0]  out_column_number,
  output logic                  out_last_of_run
);

  logic    q_valid, q_deq;
  entry_t  q_entry;
  logic    bun_valid, bun_ready;
  bundle_t bun;

  atl_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_source_byte (in_source_byte),
    .in_final_byte  (in_final_byte),
    .q_valid        (q_valid),
    .q_entry        (q_entry),
    .q_deq          (q_deq)
  );

  atl_engine #(
    .INDEX_BITS  (INDEX_BITS),
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_deq     (q_deq),
    .bun_valid (bun_valid),
    .bun       (bun),
    .bun_ready (bun_ready)
  );

  atl_serial u_serial (
    .clk               (clk),
    .rst_n             (rst_n),
    .bun_valid         (bun_valid),
    .bun               (bun),
    .bun_ready         (bun_ready),
    .empty             (empty),
    .pop               (pop),
    .out_token_kind    (out_token_kind),
    .out_start_index   (out_start_index),
    .out_token_length  (out_token_length),
    .out_line_number   (out_line_number),
    .out_column_number (out_column_number),
    .out_last_of_run   (out_last_of_run)
  );

  `ATL_ASSERT(a_stop_is_last, (pop && !empty && (out_token_kind == K_END || out_token_kind == K_ERROR)) |-> out_last_of_run, "end or error result is not last of its run")
  `ATL_ASSERT(a_quiet_after_end, (pop && !empty && out_token_kind == K_END) |=> empty, "result seen after end marker")
  `ATL_NEVER(a_no_drop, q_deq && bun_valid && !bun_ready, "byte consumed while its results were refused")

endmodule

// ----- sim/atl_token_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the assembly token lexer: re-lexes every accepted input beat
// and compares each result beat with the oldest token still due.
// Depends on atl_pkg for token kinds and output field widths.
module atl_token_checker import atl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic                  full,
  input  logic [7:0]            in_source_byte,
  input  logic                  in_final_byte,
  input  logic                  empty,
  input  logic                  pop,
  input  logic [3:0]            out_token_kind,
  input  logic [OUT_IDX_W-1:0]  out_start_index,
  input  logic [OUT_IDX_W-1:0]  out_token_length,
  input  logic [OUT_LINE_W-1:0] out_line_number,
  input  logic [OUT_COL_W-1:0]  out_column_number,
  input  logic                  out_last_of_run,
  output int                    fail_count,
  output int                    tokens_waiting
);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam int         MAX_PRINT = 100;

  typedef enum logic [3:0] {
    S_IDLE, S_HASH, S_DIRECTIVE, S_MINUS, S_NUMBER, S_DOLLAR, S_REGISTER,
    S_WORD, S_COMMENT, S_CR
  } scan_t;

  typedef struct packed {
    kind_t                 kind;
    logic [OUT_IDX_W-1:0]  start;
    logic [OUT_IDX_W-1:0]  len;
    logic [OUT_LINE_W-1:0] line;
    logic [OUT_COL_W-1:0]  col;
    logic                  last;
  } token_t;

  token_t tokens_due[$];
  token_t burst[$];

  scan_t                 mode;
  bit                    halted;
  logic [OUT_IDX_W-1:0]  pos, tok_start, tok_len;
  logic [OUT_LINE_W-1:0] line, tok_line;
  logic [OUT_COL_W-1:0]  col, tok_col;

  function automatic bit is_alpha(logic [7:0] c);
    return c >= 8'h41 && c <= 8'h7A;
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic void put_token(kind_t k, logic [OUT_IDX_W-1:0] s,
                                    logic [OUT_IDX_W-1:0] n, logic [OUT_LINE_W-1:0] ln,
                                    logic [OUT_COL_W-1:0] cl);
    token_t t;
    t.kind  = k;
    t.start = s;
    t.len   = n;
    t.line  = ln;
    t.col   = cl;
    t.last  = 1'b0;
    if (burst.size() < MAX_RES) burst.push_back(t);
  endfunction

  function automatic void open_tok(scan_t m);
    mode      = m;
    tok_start = pos;
    tok_len   = '0;
    tok_line  = line;
    tok_col   = col;
  endfunction

  // Consume one byte: offset wraps, column and pending length saturate.
  function automatic void advance();
    pos = pos + 1'b1;
    if (col != '1) col = col + 1'b1;
    if (mode != S_IDLE && tok_len != '1) tok_len = tok_len + 1'b1;
  endfunction

  function automatic void close_tok(kind_t k);
    put_token(k, tok_start, tok_len, tok_line, tok_col);
    mode = S_IDLE;
  endfunction

  function automatic void abort_tok();
    put_token(K_ERROR, tok_start, '0, tok_line, tok_col);
    mode   = S_IDLE;
    halted = 1'b1;
  endfunction

  function automatic void close_line();
    close_tok(K_NEWLINE);
    if (line != '1) line = line + 1'b1;
    col = '0;
  endfunction

  function automatic void start_tok(logic [7:0] c);
    if (c == CH_HASH) begin
      open_tok(S_HASH);
      advance();
    end else if (c == CH_MINUS) begin
      open_tok(S_MINUS);
      advance();
    end else if (is_num(c)) begin
      open_tok(S_NUMBER);
      advance();
    end else if (c == CH_DOLLAR) begin
      open_tok(S_DOLLAR);
      advance();
    end else if (is_alpha(c)) begin
      open_tok(S_WORD);
      advance();
    end else if (c == CH_SEMI) begin
      open_tok(S_COMMENT);
      advance();
    end else if (c == CH_LF) begin
      open_tok(S_CR);
      advance();
      close_line();
    end else if (c == CH_CR) begin
      open_tok(S_CR);
      advance();
    end else if (c == CH_SPACE || c == CH_TAB) begin
      advance();
    end else begin
      put_token(K_ERROR, pos, '0, line, col);
      halted = 1'b1;
    end
  endfunction

  function automatic void scan_byte(logic [7:0] c);
    bit restart;
    restart = 1'b0;
    case (mode)
      S_HASH:
        if (is_alpha(c)) begin
          mode = S_DIRECTIVE;
          advance();
        end else abort_tok();
      S_MINUS:
        if (is_num(c)) begin
          mode = S_NUMBER;
          advance();
        end else abort_tok();
      S_DOLLAR:
        if (is_num(c)) begin
          mode = S_REGISTER;
          advance();
        end else abort_tok();
      S_CR:
        if (c == CH_LF) begin
          advance();
          close_line();
        end else abort_tok();
      S_DIRECTIVE:
        if (is_alpha(c)) advance();
        else begin
          close_tok(K_DIR);
          restart = 1'b1;
        end
      S_NUMBER:
        if (is_num(c)) advance();
        else begin
          close_tok(K_NUM);
          restart = 1'b1;
        end
      S_REGISTER:
        if (is_num(c)) advance();
        else begin
          close_tok(K_REG);
          restart = 1'b1;
        end
      S_WORD:
        if (is_alpha(c) || is_num(c)) advance();
        else if (c == CH_COLON) begin
          advance();
          close_tok(K_LABEL);
        end else begin
          close_tok(K_IDENT);
          restart = 1'b1;
        end
      S_COMMENT:
        if (c != CH_CR && c != CH_LF && c != CH_NUL) advance();
        else begin
          close_tok(K_COMMENT);
          restart = 1'b1;
        end
      default: begin
        mode    = S_IDLE;
        restart = 1'b1;
      end
    endcase
    // the byte that closed a token may open the next one
    if (restart) start_tok(c);
  endfunction

  function automatic void flush_tok();
    case (mode)
      S_DIRECTIVE: close_tok(K_DIR);
      S_NUMBER:    close_tok(K_NUM);
      S_REGISTER:  close_tok(K_REG);
      S_WORD:      close_tok(K_IDENT);
      S_COMMENT:   close_tok(K_COMMENT);
      S_IDLE:      ;
      default:     abort_tok();
    endcase
  endfunction

  function automatic void lex_byte(logic [7:0] c, logic fin);
    burst.delete();
    if (halted) return;
    scan_byte(c);
    if (fin && !halted) begin
      flush_tok();
      if (!halted) begin
        put_token(K_END, pos, '0, line, col);
        halted = 1'b1;
      end
      mode = S_IDLE;
    end
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) tokens_due.push_back(burst[i]);
  endfunction

  task automatic log_mismatch(input string what);
    fail_count++;
    if (fail_count <= MAX_PRINT) $display("%0t ns mismatch: %s", $time, what);
  endtask

  task automatic check_token();
    token_t want;
    if (tokens_due.size() == 0) begin
      log_mismatch($sformatf("result beat kind %0d with no token due", out_token_kind));
      return;
    end
    want = tokens_due.pop_front();
    if (out_token_kind !== want.kind)
      log_mismatch($sformatf("token_kind got %0d want %0d", out_token_kind, want.kind));
    if (out_start_index !== want.start)
      log_mismatch($sformatf("start_index got %0d want %0d", out_start_index, want.start));
    if (out_token_length !== want.len)
      log_mismatch($sformatf("token_length got %0d want %0d", out_token_length, want.len));
    if (out_line_number !== want.line)
      log_mismatch($sformatf("line_number got %0d want %0d", out_line_number, want.line));
    if (out_column_number !== want.col)
      log_mismatch($sformatf("column_number got %0d want %0d", out_column_number,
                             want.col));
    if (out_last_of_run !== want.last)
      log_mismatch($sformatf("last_of_run got %0b want %0b", out_last_of_run, want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mode       = S_IDLE;
      halted     = 1'b0;
      pos        = '0;
      line       = '0;
      col        = '0;
      tok_start  = '0;
      tok_len    = '0;
      tok_line   = '0;
      tok_col    = '0;
      fail_count = 0;
      tokens_due.delete();
    end else begin
      if (pop && !empty) check_token();
      if (push && !full) lex_byte(in_source_byte, in_final_byte);
    end
    tokens_waiting = tokens_due.size();
  end

endmodule

// ----- sim/tb_assembly_token_lexer.sv -----
`timescale 1ns / 100ps
// Testbench top for the assembly token lexer: clock, reset, source byte
// stimulus and result-side pops; checking lives in atl_token_checker.
// Depends on atl_pkg, assembly_token_lexer and atl_token_checker.
module tb_assembly_token_lexer;
  import atl_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  push = 1'b0;
  logic                  pop = 1'b0;
  logic [7:0]            src_byte = '0;
  logic                  fin_byte = 1'b0;
  logic                  full, empty;
  logic [3:0]            tok_kind;
  logic [OUT_IDX_W-1:0]  tok_start, tok_len;
  logic [OUT_LINE_W-1:0] tok_line;
  logic [OUT_COL_W-1:0]  tok_col;
  logic                  tok_last;

  int send_idle = 0;
  int pop_idle = 0;
  int sent = 0;
  int stalled = 0;
  int fails;
  int waiting;

  always #2 clk = ~clk;

  assembly_token_lexer uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_source_byte    (src_byte),
    .in_final_byte     (fin_byte),
    .empty             (empty),
    .pop               (pop),
    .out_token_kind    (tok_kind),
    .out_start_index   (tok_start),
    .out_token_length  (tok_len),
    .out_line_number   (tok_line),
    .out_column_number (tok_col),
    .out_last_of_run   (tok_last)
  );

  atl_token_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_source_byte    (src_byte),
    .in_final_byte     (fin_byte),
    .empty             (empty),
    .pop               (pop),
    .out_token_kind    (tok_kind),
    .out_start_index   (tok_start),
    .out_token_length  (tok_len),
    .out_line_number   (tok_line),
    .out_column_number (tok_col),
    .out_last_of_run   (tok_last),
    .fail_count        (fails),
    .tokens_waiting    (waiting)
  );

  always @(negedge clk) pop <= ($urandom_range(99) >= pop_idle);

  // Abort when no beat moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      stalled <= 0;
    end else if (stalled >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stalled <= stalled + 1;
    end
  end

  // Entered and left at a falling edge; push stays high between back-to-back beats.
  task automatic send_byte(input logic [7:0] b, input logic fin = 1'b0);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push     <= 1'b1;
    src_byte <= b;
    fin_byte <= fin;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    return 8'($urandom_range(8'h41, 8'h7A));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'($urandom_range(8'h30, 8'h39));
  endfunction

  function automatic logic [7:0] rand_word_char();
    return ($urandom_range(3) == 0) ? rand_digit() : rand_letter();
  endfunction

  function automatic logic [7:0] rand_blank();
    return $urandom_range(1) ? 8'h20 : 8'h09;
  endfunction

  function automatic logic [7:0] rand_comment_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == 8'h0A || c == 8'h0D);
    return c;
  endfunction

  // Well-formed tokens with random content; adjacent tokens may run together.
  task automatic send_random_token();
    int n;
    n = $urandom_range(1, 6);
    case ($urandom_range(9))
      0: begin
        send_byte("#");
        repeat (n) send_byte(rand_letter());
        // keep a following label from running into the directive
        send_byte(rand_blank());
      end
      1: begin
        if ($urandom_range(1)) send_byte("-");
        repeat (n) send_byte(rand_digit());
      end
      2: begin
        send_byte("$");
        repeat (n) send_byte(rand_digit());
      end
      3: begin
        send_byte(rand_letter());
        repeat (n - 1) send_byte(rand_word_char());
        send_byte(":");
      end
      4, 5: begin
        send_byte(rand_letter());
        repeat (n - 1) send_byte(rand_word_char());
      end
      6: begin
        send_byte(";");
        repeat ($urandom_range(12)) send_byte(rand_comment_char());
      end
      7: send_byte(8'h0A);
      8: begin
        send_byte(8'h0D);
        send_byte(8'h0A);
      end
      default: repeat (n) send_byte(rand_blank());
    endcase
    repeat ($urandom_range(2)) send_byte(rand_blank());
  endtask

  task automatic run_random(input int count);
    int target;
    target = sent + count;
    while (sent < target) send_random_token();
  endtask

  // Close the source: a clean end of file or one of the ways lexing stops.
  task automatic finish_source();
    send_byte(8'h0A);
    case ($urandom_range(8))
      0: begin
        send_text("ab");
        send_byte(8'h0A, 1'b1);
      end
      1: send_byte("x", 1'b1);
      2: send_text("# ");
      3: send_text("-a");
      4: send_text("$;");
      5: begin
        send_byte(8'h0D);
        send_byte("a");
      end
      6: begin
        send_text(";k");
        send_byte(8'h00);
      end
      7: send_byte($urandom_range(1) ? 8'h40 : 8'($urandom_range(8'h7B, 8'hFF)));
      default: send_byte("#", 1'b1);
    endcase
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle = 37;
    pop_idle  = 59;
    send_text("#A[z -09 $0\t_");
    send_byte(8'h60);
    send_text(":x9;");
    send_byte(8'hFF);
    send_text("~\r\n\n9z\n");
    run_random(55);

    send_idle = 59;
    pop_idle  = 37;
    run_random(55);

    send_idle = 0;
    pop_idle  = 0;
    run_random(50);
    send_text("ab #q\n");
    finish_source();
    // lexer has stopped: these beats must produce nothing
    repeat (12) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    push <= 1'b0;

    while (waiting != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fails == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
